// ----- src/lpst_pkg.sv -----
// ---------------------------------------------------------------------------
// lpst_pkg
// shared widths, constants and types for the line phase slot tracker
// ---------------------------------------------------------------------------
package lpst_pkg;

  localparam int DEFAULT_NUM_SLOTS = 8;

  localparam int KEY_W  = 16;
  localparam int PX_W   = 16;
  localparam int COL_W  = 8;
  localparam int ADV_W  = 8;
  localparam int GEN_W  = 8;
  localparam int CB_W   = 8;
  localparam int SLOT_OUT_W = 3;
  // low bits of a phase sum that reach bits [10:3]
  localparam int OFF_W  = 11;

  // s_axis_tdata: 80 bits, m_axis_tdata: 51 bits padded to 56
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (PX_W + COL_W + SLOT_OUT_W + PX_W + COL_W);

  localparam logic [KEY_W-1:0] KEY_MASK          = 16'hFFF0;
  localparam logic [GEN_W-1:0] GEN_MAX           = 8'd255;
  localparam logic [ADV_W-1:0] DEFAULT_ADV_RESET = 8'd12;

  typedef struct packed {
    logic [ADV_W-1:0] adv;
    logic [COL_W-1:0] cur_col;
    logic [CB_W-1:0]  cbase;
    logic [KEY_W-1:0] key;
  } in_item_t;

endpackage

// ----- src/line_phase_slot_tracker_unit.sv -----
// ---------------------------------------------------------------------------
// line_phase_slot_tracker_unit
// slot table that follows the pixel phase of text lines; while results drain, one glyph per cycle
// ---------------------------------------------------------------------------
// a taken input is held in the input register, then in the result register
// throughput: one glyph per cycle while results drain, set by the read-modify-write
//   of the slot table between the input register and the result register
// reset (rst, synchronous, active high): all slots and the generation counter
//   clear to zero, default_advance returns to 12, both stages go empty
module line_phase_slot_tracker_unit #(
  parameter int NUM_SLOTS = lpst_pkg::DEFAULT_NUM_SLOTS
) (
  input  logic                             clk,
  input  logic                             rst,
  // default_advance register
  input  logic                             cfg_we,
  input  logic [lpst_pkg::ADV_W-1:0]       cfg_wdata,
  // glyph request stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tile_base[15:0], cursor_row[23:16], cursor_col[31:24], cursor_tile_row[39:32],
  // template_addr_low[55:40], cbase[63:56], cursor_tile_col[71:64],
  // advance[79:72]
  input  logic [lpst_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // start_px[15:0], base_tile_col[23:16], slot_index[26:24], end_px[42:27],
  // new_cursor_tile_col[50:43], zero fill[55:51]
  output logic [lpst_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // hit[0]
  output logic [0:0]                       m_axis_tuser
);

  import lpst_pkg::*;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // slot table, all in flip-flops
  logic [KEY_W-1:0] slot_key      [NUM_SLOTS];
  logic [PX_W-1:0]  slot_px       [NUM_SLOTS];
  logic [COL_W-1:0] slot_base_col [NUM_SLOTS];
  logic [ADV_W-1:0] slot_prev_adv [NUM_SLOTS];
  logic [GEN_W-1:0] slot_gen      [NUM_SLOTS];
  logic [CB_W-1:0]  slot_cbase    [NUM_SLOTS];
  logic [GEN_W-1:0] gen_count;
  logic [ADV_W-1:0] default_advance;

  // input stage
  in_item_t         in_item;
  in_item_t         item_q;
  logic             in_valid;
  logic             proc;

  // result stage
  logic             out_valid;
  logic [PX_W-1:0]  out_start_px;
  logic [COL_W-1:0] out_base_col;
  logic [SLOT_OUT_W-1:0] out_slot;
  logic             out_hit;
  logic [PX_W-1:0]  out_end_px;
  logic [COL_W-1:0] out_new_col;

  // lookup and update
  logic [NUM_SLOTS-1:0] match;
  logic             hit_any;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] victim_idx;
  logic [GEN_W-1:0] victim_gen;
  logic [IDX_W-1:0] sel;
  logic [PX_W-1:0]  sel_px;
  logic [COL_W-1:0] sel_base;
  logic [ADV_W-1:0] sel_last;
  logic [ADV_W-1:0] prev_adv;
  logic [OFF_W-1:0] step_sum;
  logic [COL_W-1:0] expect_col;
  logic             broken;
  logic [PX_W-1:0]  px_eff;
  logic [COL_W-1:0] base_eff;
  logic [PX_W-1:0]  end_px;
  logic [OFF_W-1:0] off_sum;
  logic [COL_W-1:0] new_col;
  logic [GEN_W-1:0] gen_next;

  // line key and field unpack
  always_comb begin
    in_item.key = s_axis_tdata[15:0]
                ^ {s_axis_tdata[23:16], 8'h00}
                ^ {4'h0, s_axis_tdata[31:24], 4'h0}
                ^ {8'h00, s_axis_tdata[39:32]}
                ^ (s_axis_tdata[55:40] & KEY_MASK);
    in_item.cbase   = s_axis_tdata[63:56];
    in_item.cur_col = s_axis_tdata[71:64];
    in_item.adv     = s_axis_tdata[79:72];
  end

  // the held item moves on whenever the result register is free or drains
  assign proc          = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_advance <= DEFAULT_ADV_RESET;
    end else if (cfg_we) begin
      default_advance <= cfg_wdata;
    end
  end

  // parallel match on key and char base, lowest index wins
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      match[i] = (slot_key[i] == item_q.key) && (slot_cbase[i] == item_q.cbase);
    end
    hit_any = |match;
    hit_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
  end

  // replacement victim: oldest generation strictly below the max, first on a tie,
  // slot 0 when every slot sits at the max
  always_comb begin
    victim_gen = GEN_MAX;
    victim_idx = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (slot_gen[i] < victim_gen) begin
        victim_gen = slot_gen[i];
        victim_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    sel      = hit_any ? hit_idx : victim_idx;
    sel_px   = slot_px[sel];
    sel_base = slot_base_col[sel];
    sel_last = slot_prev_adv[sel];
    prev_adv = (sel_last != '0) ? sel_last : default_advance;

    // continuity check: only bits [10:3] of the phase sum reach the column
    step_sum   = sel_px[OFF_W-1:0] + {{(OFF_W-ADV_W){1'b0}}, prev_adv} - OFF_W'(1);
    expect_col = sel_base + step_sum[OFF_W-1:3];
    broken     = (item_q.cur_col <= sel_base) || (item_q.cur_col != expect_col);

    if (hit_any && (sel_px != '0) && !broken) begin
      // line run continues
      px_eff   = sel_px;
      base_eff = sel_base;
    end else begin
      // new run: miss, zero phase, or a broken run
      px_eff   = '0;
      base_eff = item_q.cur_col;
    end

    end_px   = px_eff + {{(PX_W-ADV_W){1'b0}}, item_q.adv};
    // wraps at 11 bits, so a zero sum gives all ones in bits [10:3]
    off_sum  = end_px[OFF_W-1:0] + {{(OFF_W-ADV_W){1'b0}}, item_q.adv} - OFF_W'(1);
    new_col  = base_eff + off_sum[OFF_W-1:3];
    gen_next = gen_count + GEN_W'(1);
  end

  // slot table update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_key[i]       <= '0;
        slot_px[i]        <= '0;
        slot_base_col[i]  <= '0;
        slot_prev_adv[i]  <= '0;
        slot_gen[i]       <= '0;
        slot_cbase[i]     <= '0;
      end
      gen_count <= '0;
    end else if (proc) begin
      gen_count           <= gen_next;
      slot_gen[sel]       <= gen_next;
      slot_px[sel]        <= end_px;
      slot_base_col[sel]  <= base_eff;
      slot_prev_adv[sel]  <= item_q.adv;
      if (!hit_any) begin
        slot_key[sel]   <= item_q.key;
        slot_cbase[sel] <= item_q.cbase;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_start_px <= px_eff;
      out_base_col <= base_eff;
      out_slot     <= SLOT_OUT_W'(sel);
      out_hit      <= hit_any;
      out_end_px   <= end_px;
      out_new_col  <= new_col;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_new_col, out_end_px, out_slot,
                          out_base_col, out_start_px};
  assign m_axis_tuser  = out_hit;

endmodule

// ----- src/lpst_checker.sv -----
// ---------------------------------------------------------------------------
// lpst_checker
// port-level checks for the line phase slot tracker
// ---------------------------------------------------------------------------
module lpst_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [lpst_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [0:0]                       m_axis_tuser
);

  import lpst_pkg::*;

  // no result survives reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // a stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

  // input side only stalls when a full result is backed up
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");

  // a newly bound slot always starts at phase zero
  a_miss_phase: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[PX_W-1:0] == '0))
    else $error("miss with nonzero start phase");

  // the new cursor column is relative to the run's base column: with zero start
  // phase the end phase equals the advance, so it fits in 8 bits
  a_end_phase: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[42:27] <= 16'd255))
    else $error("miss end phase beyond one advance");

endmodule

bind line_phase_slot_tracker_unit lpst_checker u_lpst_checker (.*);
